// ----- hdl/fre_pkg.sv -----
// Shared constants, types and controller/datapath bundles for the frame row
// delta encoder. No dependencies; every other file imports this package.
package fre_pkg;

    // Frame geometry
    localparam int ROWS          = 480;
    localparam int ROW_W         = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SEGS          = 32;
    localparam int SEG_IDX_W     = $clog2(SEGS);
    localparam int WORD_W        = 32;
    localparam int WORDS_PER_SEG = 5;
    localparam int SEG_W         = WORD_W * WORDS_PER_SEG;
    localparam int REF_DEPTH     = ROWS * SEGS;
    localparam int REF_AW        = ROW_W + SEG_IDX_W;

    // Byte accounting (compares are done one bit wider than the counter)
    localparam int BYTES_W   = 19;
    localparam int SUM_W     = BYTES_W + 1;
    localparam logic [SUM_W-1:0] BYTES_MAX  = SUM_W'((1 << BYTES_W) - 1);
    localparam logic [SUM_W-1:0] ROW_BYTES  = SUM_W'(4);
    localparam logic [SUM_W-1:0] SEG_BYTES  = SUM_W'(4 * WORDS_PER_SEG);
    localparam logic [SUM_W-1:0] BASE_BYTES = SUM_W'(ROWS * 4);
    localparam logic [SUM_W-1:0] RAW_BYTES  = SUM_W'(ROWS * SEGS * WORDS_PER_SEG * 4);

    typedef logic [SEG_W-1:0] seg_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_MASK = 2'd0,
        KIND_SEG  = 2'd1,
        KIND_SUM  = 2'd2
    } kind_t;

    // Controller to datapath
    typedef struct packed {
        logic ready;      // input channel may transfer
        logic cmp;        // compare held segment, write stores
        logic load_mask;  // load row mask result
        logic scan_rd;    // read row buffer at scan index
        logic load_seg;   // load changed segment result, advance scan
        logic load_sum;   // load frame summary, restart frame
        logic shift;      // skip an unchanged segment
        logic row_adv;    // step to next row
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_valid;
        logic seg_last;
        logic row_last;
        logic walk_zero;
        logic walk_lsb;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- hdl/fre_if.sv -----
// Valid/ready stream interfaces for segments in and results out.
// Depends on fre_pkg for widths.
interface fre_seg_if;
    import fre_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] seg_word_0;
    logic [WORD_W-1:0] seg_word_1;
    logic [WORD_W-1:0] seg_word_2;
    logic [WORD_W-1:0] seg_word_3;
    logic [WORD_W-1:0] seg_word_4;

    modport source (output valid, seg_word_0, seg_word_1, seg_word_2, seg_word_3,
                    seg_word_4, input ready);
    modport sink   (input valid, seg_word_0, seg_word_1, seg_word_2, seg_word_3,
                    seg_word_4, output ready);
endinterface

interface fre_res_if;
    import fre_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [WORD_W-1:0]  out_word_0;
    logic [WORD_W-1:0]  out_word_1;
    logic [WORD_W-1:0]  out_word_2;
    logic [WORD_W-1:0]  out_word_3;
    logic [WORD_W-1:0]  out_word_4;
    logic [BYTES_W-1:0] delta_bytes;
    logic               frame_changed;
    logic               delta_smaller;
    logic               last;

    modport source (output valid, kind, out_word_0, out_word_1, out_word_2, out_word_3,
                    out_word_4, delta_bytes, frame_changed, delta_smaller, last,
                    input ready);
    modport sink   (input valid, kind, out_word_0, out_word_1, out_word_2, out_word_3,
                    out_word_4, delta_bytes, frame_changed, delta_smaller, last,
                    output ready);
endinterface

// ----- hdl/fre_ctrl.sv -----
// Sequencing state machine: per-segment compare, then the end-of-row
// mask / changed-segment walk and end-of-frame summary. Depends on fre_pkg.
module fre_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  fre_pkg::dp_stat_t stat,
    output fre_pkg::ctrl_cmd_t cmd
);
    import fre_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_MASK,
        ST_SCAN,
        ST_OUT,
        ST_SUM
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.ready     = ready_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (stat.in_valid && ready_reg)
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = stat.seg_last ? ST_MASK : ST_IDLE;
            end
            ST_MASK:
            begin
                if (stat.out_free)
                begin
                    cmd.load_mask = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.walk_zero)
                begin
                    if (stat.row_last)
                        state_next = ST_SUM;
                    else
                    begin
                        cmd.row_adv = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
                else if (stat.walk_lsb)
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = ST_OUT;
                end
                else
                    cmd.shift = 1'b1;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_seg = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_SUM:
            begin
                if (stat.out_free)
                begin
                    cmd.load_sum = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

// ----- hdl/fre_dpath.sv -----
// Datapath: reference frame store, row buffer, change mask, counters and the
// result output register. Depends on fre_pkg and the stream interfaces.
module fre_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  fre_pkg::ctrl_cmd_t cmd,
    output fre_pkg::dp_stat_t  stat,
    fre_seg_if.sink            segment,
    fre_res_if.source          result
);
    import fre_pkg::*;

    // Stores
    seg_t ref_mem [0:REF_DEPTH-1];
    seg_t row_mem [0:SEGS-1];

    // Counters and row state
    logic [SEG_IDX_W-1:0] seg_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [SEGS-1:0]      mask_reg;
    logic [SEGS-1:0]      walk_reg;
    logic [SEG_IDX_W-1:0] idx_reg;
    logic [BYTES_W-1:0]   bytes_reg, bytes_next;
    logic                 ref_valid_reg;   // set once the first frame is stored
    logic                 last_pend_reg;

    // Payload holding registers
    seg_t in_reg;
    seg_t ref_rd_reg;
    seg_t row_rd_reg;

    // Output register
    logic               out_valid_reg;
    kind_t              kind_reg;
    seg_t               out_seg_reg;
    logic [BYTES_W-1:0] out_bytes_reg;
    logic               out_changed_reg;
    logic               out_smaller_reg;
    logic               out_last_reg;

    logic              fire;
    logic [REF_AW-1:0] ref_addr;
    seg_t              ref_data;
    logic              diff;
    logic [SUM_W-1:0]  byte_inc;
    logic [SUM_W-1:0]  byte_sum;
    logic              out_free;
    logic              row_last;

    assign fire     = segment.valid && cmd.ready;
    assign ref_addr = {row_reg, seg_reg};
    assign row_last = (row_reg == ROW_W'(ROWS - 1));
    assign out_free = !out_valid_reg || result.ready;

    // Reference reads of the first frame after reset see zeros
    assign ref_data = ref_valid_reg ? ref_rd_reg : '0;
    assign diff     = |(in_reg ^ ref_data);

    // Saturating byte count
    assign byte_inc = cmd.load_mask ? ROW_BYTES : SEG_BYTES;
    assign byte_sum = {1'b0, bytes_reg} + byte_inc;
    always_comb
    begin
        bytes_next = bytes_reg;
        if (cmd.load_sum)
            bytes_next = '0;
        else if (cmd.load_mask || cmd.load_seg)
            bytes_next = (byte_sum > BYTES_MAX) ? BYTES_MAX[BYTES_W-1:0]
                                                : byte_sum[BYTES_W-1:0];
    end

    // Reference store: read on transfer, write back on compare
    always_ff @(posedge clk)
    begin
        if (fire)
            ref_rd_reg <= ref_mem[ref_addr];
        if (cmd.cmp)
            ref_mem[ref_addr] <= in_reg;
    end

    // Row buffer: written on compare, read during the walk
    always_ff @(posedge clk)
    begin
        if (cmd.cmp)
            row_mem[seg_reg] <= in_reg;
        if (cmd.scan_rd)
            row_rd_reg <= row_mem[idx_reg];
    end

    // Input capture
    always_ff @(posedge clk)
    begin
        if (fire)
            in_reg <= {segment.seg_word_4, segment.seg_word_3, segment.seg_word_2,
                       segment.seg_word_1, segment.seg_word_0};
    end

    // Control counters and mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg       <= '0;
            row_reg       <= '0;
            mask_reg      <= '0;
            walk_reg      <= '0;
            idx_reg       <= '0;
            bytes_reg     <= '0;
            ref_valid_reg <= 1'b0;
            last_pend_reg <= 1'b0;
        end
        else
        begin
            bytes_reg <= bytes_next;
            if (cmd.cmp)
            begin
                mask_reg <= {diff, mask_reg[SEGS-1:1]};
                seg_reg  <= seg_reg + 1'b1;
                if (seg_reg == SEG_IDX_W'(SEGS - 1))
                begin
                    walk_reg <= {diff, mask_reg[SEGS-1:1]};
                    idx_reg  <= '0;
                end
            end
            if (cmd.scan_rd)
                last_pend_reg <= (walk_reg[SEGS-1:1] == '0) && !row_last;
            if (cmd.shift || cmd.load_seg)
            begin
                walk_reg <= walk_reg >> 1;
                idx_reg  <= idx_reg + 1'b1;
            end
            if (cmd.row_adv)
                row_reg <= row_reg + 1'b1;
            if (cmd.load_sum)
            begin
                row_reg       <= '0;
                ref_valid_reg <= 1'b1;
            end
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_mask || cmd.load_seg || cmd.load_sum)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_mask)
        begin
            kind_reg        <= KIND_MASK;
            out_seg_reg     <= {(SEG_W - SEGS)'(0), walk_reg};
            out_bytes_reg   <= '0;
            out_changed_reg <= 1'b0;
            out_smaller_reg <= 1'b0;
            out_last_reg    <= (walk_reg == '0) && !row_last;
        end
        else if (cmd.load_seg)
        begin
            kind_reg        <= KIND_SEG;
            out_seg_reg     <= row_rd_reg;
            out_bytes_reg   <= '0;
            out_changed_reg <= 1'b0;
            out_smaller_reg <= 1'b0;
            out_last_reg    <= last_pend_reg;
        end
        else if (cmd.load_sum)
        begin
            kind_reg        <= KIND_SUM;
            out_seg_reg     <= '0;
            out_bytes_reg   <= bytes_reg;
            out_changed_reg <= ({1'b0, bytes_reg} != BASE_BYTES);
            out_smaller_reg <= ({1'b0, bytes_reg} < RAW_BYTES);
            out_last_reg    <= 1'b1;
        end
    end

    assign segment.ready        = cmd.ready;
    assign result.valid         = out_valid_reg;
    assign result.kind          = kind_reg;
    assign result.out_word_0    = out_seg_reg[0*WORD_W +: WORD_W];
    assign result.out_word_1    = out_seg_reg[1*WORD_W +: WORD_W];
    assign result.out_word_2    = out_seg_reg[2*WORD_W +: WORD_W];
    assign result.out_word_3    = out_seg_reg[3*WORD_W +: WORD_W];
    assign result.out_word_4    = out_seg_reg[4*WORD_W +: WORD_W];
    assign result.delta_bytes   = out_bytes_reg;
    assign result.frame_changed = out_changed_reg;
    assign result.delta_smaller = out_smaller_reg;
    assign result.last          = out_last_reg;

    assign stat.in_valid  = segment.valid;
    assign stat.seg_last  = (seg_reg == SEG_IDX_W'(SEGS - 1));
    assign stat.row_last  = row_last;
    assign stat.walk_zero = (walk_reg == '0);
    assign stat.walk_lsb  = walk_reg[0];
    assign stat.out_free  = out_free;

    // A transfer is always followed by its compare
    a_fire_cmp: assert property (@(posedge clk) disable iff (!rst_n) fire |=> cmd.cmp)
        else $error("compare did not follow input transfer");

    // Results are only loaded into a free output slot
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_mask || cmd.load_seg || cmd.load_sum) |-> out_free)
        else $error("result loaded over a held result");

    // Summary only after the last row
    a_sum_row: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_sum |-> row_last)
        else $error("summary outside last row");

    // A changed segment is only emitted when its mask bit was set
    a_seg_bit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_rd |-> walk_reg[0])
        else $error("row buffer read for unchanged segment");

endmodule

// ----- hdl/frame_row_delta_encoder.sv -----
// Top level of the frame row delta encoder: controller plus datapath.
// Depends on fre_pkg, fre_seg_if/fre_res_if, fre_ctrl and fre_dpath.
//
//  Port     | Dir  | Transfer moves
//  ---------+------+-------------------------------------------------
//  segment  | sink | one five-word segment, raster order, 32 per row
//  result   | src  | row mask, changed segment or frame summary
//
//  A mid-row segment takes a reference read on transfer, then compare and
//  write. The last segment of a row adds a mask step, a walk over the mask
//  with an output step per changed segment, a row-end step and a summary step
//  on the final row; the row buffer read port and the single output register
//  set this. No clearing pass: the reference store reads as zero until the
//  first frame after reset is written. Result stalls hold the walk in place.
module frame_row_delta_encoder (
    input  logic      clk,
    input  logic      rst_n,
    fre_seg_if.sink   segment,
    fre_res_if.source result
);
    import fre_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    fre_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    fre_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .segment (segment),
        .result  (result)
    );

endmodule
